/* rtl/rope_pkg.sv */
// Package: bf16 types and arithmetic functions for the rotary embedding block.
`timescale 1ns / 1ps
`default_nettype none
package rope_pkg;

    typedef logic [15:0] bf16_t;

    localparam bf16_t BF16_QNAN = 16'h7FC0;
    localparam bf16_t BF16_INF  = 16'h7F80;

    // Round an unpacked value to bf16.
    // sign, biased exponent e (value = sig * 2^(e-127-SW+1)), significand with
    // leading one at bit 10 (8 kept bits + guard + 2 extra) and sticky.
    function automatic bf16_t bf_round(input logic sign, input logic signed [10:0] e,
                                       input logic [10:0] sig, input logic sticky);
        logic [10:0]        m;
        logic               st;
        logic [4:0]         sh;
        logic [8:0]         q;
        logic               g;
        logic               r;
        logic signed [10:0] be;
        logic [11:0]        tmp;
        m  = sig;
        st = sticky;
        be = e;
        if (e < 11'sd1) begin
            if (e < -11'sd12)
                sh = 5'd12;
            else
                sh = 5'(11'sd1 - e);
            tmp = {m, 1'b0} >> sh;
            st  = st | (|(m & ~(11'h7FF << sh)));
            m   = tmp[11:1];
            be  = 11'sd0;
        end
        q = {1'b0, m[10:3]};
        g = m[2];
        r = m[1] | m[0] | st;
        if (g && (r || q[0]))
            q = q + 9'd1;
        if (be == 11'sd0) begin
            // subnormal path: q[7] set means smallest normal
            bf_round = {sign, q[7] ? 8'd1 : 8'd0, q[6:0]};
        end else begin
            if (q[8]) begin
                be = be + 11'sd1;
                q  = q >> 1;
            end
            if (be >= 11'sd255)
                bf_round = {sign, BF16_INF[14:0]};
            else
                bf_round = {sign, be[7:0], q[6:0]};
        end
    endfunction

    function automatic bf16_t bf_mul(input bf16_t a, input bf16_t b);
        logic               sa;
        logic               sb;
        logic               s;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [7:0]         ma;
        logic [7:0]         mb;
        logic [15:0]        p;
        logic signed [10:0] e;
        logic [3:0]         lz;
        logic               nan_a;
        logic               nan_b;
        logic               inf_a;
        logic               inf_b;
        logic               zero_a;
        logic               zero_b;
        sa = a[15];
        sb = b[15];
        s  = sa ^ sb;
        ea = a[14:7];
        eb = b[14:7];
        ma = {ea != 8'd0, a[6:0]};
        mb = {eb != 8'd0, b[6:0]};
        nan_a  = (ea == 8'hFF) && (a[6:0] != 7'd0);
        nan_b  = (eb == 8'hFF) && (b[6:0] != 7'd0);
        inf_a  = (ea == 8'hFF) && (a[6:0] == 7'd0);
        inf_b  = (eb == 8'hFF) && (b[6:0] == 7'd0);
        zero_a = (a[14:0] == 15'd0);
        zero_b = (b[14:0] == 15'd0);
        p  = ma * mb;
        lz = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (p[i] == 1'b0 && lz == 4'(15 - i))
                lz = lz + 4'd1;
        end
        // value = p * 2^(Ea+Eb-254-14), Ea=max(ea,1)
        e = 11'($signed({3'd0, (ea == 8'd0) ? 8'd1 : ea}))
          + 11'($signed({3'd0, (eb == 8'd0) ? 8'd1 : eb})) - 11'sd126
          - 11'($signed({7'd0, lz}));
        p = p << lz;
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a))
            bf_mul = BF16_QNAN;
        else if (inf_a || inf_b)
            bf_mul = {s, BF16_INF[14:0]};
        else if (zero_a || zero_b)
            bf_mul = {s, 15'd0};
        else
            bf_mul = bf_round(s, e, p[15:5], |p[4:0]);
    endfunction

    function automatic bf16_t bf_add(input bf16_t a, input bf16_t b);
        logic               sa;
        logic               sb;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [7:0]         xa;
        logic [7:0]         xb;
        logic [7:0]         d;
        logic [7:0]         ebig;
        logic               sbig;
        logic               ssml;
        logic [11:0]        big;
        logic [11:0]        sml;
        logic               st;
        logic [12:0]        sum;
        logic [3:0]         lz;
        logic signed [10:0] e;
        logic               nan_a;
        logic               nan_b;
        logic               inf_a;
        logic               inf_b;
        logic [11:0]        mbig;
        logic [11:0]        msml;
        sa = a[15];
        sb = b[15];
        ea = a[14:7];
        eb = b[14:7];
        nan_a = (ea == 8'hFF) && (a[6:0] != 7'd0);
        nan_b = (eb == 8'hFF) && (b[6:0] != 7'd0);
        inf_a = (ea == 8'hFF) && (a[6:0] == 7'd0);
        inf_b = (eb == 8'hFF) && (b[6:0] == 7'd0);
        xa = (ea == 8'd0) ? 8'd1 : ea;
        xb = (eb == 8'd0) ? 8'd1 : eb;
        // 12-bit magnitude: 1.7 then 3 guard bits
        mbig = {1'b0, ea != 8'd0, a[6:0], 3'd0};
        msml = {1'b0, eb != 8'd0, b[6:0], 3'd0};
        if (b[14:0] > a[14:0]) begin
            ebig = xb;
            sbig = sb;
            ssml = sa;
            d    = xb - xa;
            big  = msml;
            sml  = mbig;
        end else begin
            ebig = xa;
            sbig = sa;
            ssml = sb;
            d    = xa - xb;
            big  = mbig;
            sml  = msml;
        end
        if (d > 8'd11)
            d = 8'd11;
        st  = |(sml & ~(12'hFFF << d));
        sml = sml >> d;
        if (sbig == ssml)
            sum = {1'b0, big} + {1'b0, sml};
        else
            sum = {1'b0, big} - {1'b0, sml} - {12'd0, st};
        // sum bit 10 has 2^(ebig) weight, bit 11 is one above leading; align to 11-bit sig
        lz = 4'd0;
        for (int i = 12; i >= 0; i--) begin
            if (sum[i] == 1'b0 && lz == 4'(12 - i))
                lz = lz + 4'd1;
        end
        e = 11'($signed({3'd0, ebig})) + 11'sd2 - 11'($signed({7'd0, lz}));
        sum = sum << lz;
        if (nan_a || nan_b || (inf_a && inf_b && sa != sb))
            bf_add = BF16_QNAN;
        else if (inf_a)
            bf_add = a;
        else if (inf_b)
            bf_add = b;
        else if (sum == 13'd0 && !st)
            bf_add = {sa & sb, 15'd0};
        else
            bf_add = bf_round(sbig, e, sum[12:2], |sum[1:0] | st);
    endfunction

endpackage
`default_nettype wire

/* rtl/rope_if.sv */
// Interface: valid/ready channel carrying one item.
`timescale 1ns / 1ps
`default_nettype none
interface rope_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/rope_lane.sv */
// Module: one bf16 rotate-half lane, combinational.
`timescale 1ns / 1ps
`default_nettype none
module rope_lane
    import rope_pkg::*;
(
    input  wire bf16_t x1,
    input  wire bf16_t x2,
    input  wire bf16_t c,
    input  wire bf16_t s,
    output bf16_t      r1,
    output bf16_t      r2
);
    bf16_t x1_cos;
    bf16_t x2_sin;
    bf16_t x2_cos;
    bf16_t x1_sin;

    assign x1_cos = bf_mul(x1, c);
    assign x2_sin = bf_mul(x2, s);
    assign x2_cos = bf_mul(x2, c);
    assign x1_sin = bf_mul(x1, s);

    assign r1 = bf_add(x1_cos, {~x2_sin[15], x2_sin[14:0]});
    assign r2 = bf_add(x2_cos, x1_sin);
endmodule
`default_nettype wire

/* rtl/rotary_embedding_bf16.sv */
// Top level: rotary position embedding, rotate-half form, on bf16 lanes.
// Usage:
//   in  (sink)  : data holds LANES lanes of 64 bits each, lane l at [64l+63:64l],
//                 as {sine, cosine, second_half, first_half}, 16 bits each.
//   out (source): data holds LANES lanes of 32 bits each, lane l at [32l+31:32l],
//                 as {rotated_second, rotated_first}.
//   An item moves on a clock edge with valid and ready both high.
//   The result is registered and is valid in the cycle after the item is accepted.
//   Throughput: one item per cycle while out.ready is high; set by the single output register stage.
//   in.ready is high whenever the output register is empty or being taken,
//   so a stalled receiver holds the result and back-pressures the input.
//   Reset clears the output valid flag; no item is in flight after reset.
`timescale 1ns / 1ps
`default_nettype none
module rotary_embedding_bf16
    import rope_pkg::*;
#(
    parameter int LANES = 2
)
(
    input wire clk,
    input wire rst_n,
    rope_if.sink   in,
    rope_if.source out
);
    logic                  valid_reg;
    logic [LANES*32-1:0]   data_reg;
    logic [LANES*32-1:0]   data_next;

    genvar l;
    generate
        for (l = 0; l < LANES; l++) begin : g_lane
            rope_lane u_lane (
                .x1(in.data[64*l +: 16]),
                .x2(in.data[64*l+16 +: 16]),
                .c (in.data[64*l+32 +: 16]),
                .s (in.data[64*l+48 +: 16]),
                .r1(data_next[32*l +: 16]),
                .r2(data_next[32*l+16 +: 16])
            );
        end
    endgenerate

    assign in.ready  = !valid_reg || out.ready;
    assign out.valid = valid_reg;
    assign out.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in.ready)
            valid_reg <= in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
            data_reg <= data_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(out.data))
        else $error("result dropped under stall");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in.valid && in.ready |=> out.valid)
        else $error("accepted item did not produce result");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out.valid |-> in.ready)
        else $error("empty stage refused item");
endmodule
`default_nettype wire
